>>> rtl/core/mbp_pkg.sv
// Package for the MSB-first bit packer: request codes, controller states,
// constants and the command and status structs that join controller and datapath.
// It depends on nothing else.
package mbp_pkg;

    localparam int ACC_WIDTH = 32;
    localparam int MAX_BYTES = 65536;
    localparam int POS_WIDTH = 16;
    localparam int CAP_WIDTH = 16;
    localparam int LEN_WIDTH = 6;
    localparam int CNT_WIDTH = 3;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'hFFFF;
    localparam logic [LEN_WIDTH-1:0] FREE_RESET = 6'd32;
    localparam logic [CNT_WIDTH-1:0] BYTES_PER_WORD = 3'd4;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_ALIGN   = 2'd1,
        REQ_CLOSE   = 2'd2,
        REQ_RESTART = 2'd3
    } req_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic accept;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic send_pending;
        logic final_word;
    } dp_status_t;

endpackage

>>> rtl/core/mbp_ctrl.sv
// Controller of the MSB-first bit packer: a two-state machine that gates the
// input and output handshakes and issues accept and step commands.
// Depends on mbp_pkg.
module mbp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  mbp_pkg::dp_status_t    status,
    output mbp_pkg::ctrl_cmd_t     cmd
);

    mbp_pkg::state_t state_reg;
    mbp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        out_valid  = 1'b0;
        in_stall   = 1'b0;
        cmd.step   = 1'b0;
        cmd.accept = 1'b0;
        case (state_reg)
            mbp_pkg::ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.send_pending)
                begin
                    state_next = mbp_pkg::ST_SEND;
                end
            end
            mbp_pkg::ST_SEND:
            begin
                out_valid  = 1'b1;
                cmd.step   = !out_stall;
                in_stall   = !(!out_stall && status.final_word);
                cmd.accept = in_valid && !in_stall;
                if (!out_stall && status.final_word)
                begin
                    if (in_valid && status.send_pending)
                    begin
                        state_next = mbp_pkg::ST_SEND;
                    end
                    else
                    begin
                        state_next = mbp_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = mbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/mbp_datapath.sv
// Datapath of the MSB-first bit packer: accumulator, free-bit count, byte
// position, overflow flag, send word and capacity register.
// Depends on mbp_pkg; driven by commands from mbp_ctrl.
module mbp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mbp_pkg::CAP_WIDTH-1:0]     cfg_data,
    input  logic [1:0]                        req_type,
    input  logic [31:0]                       field_value,
    input  logic [5:0]                        field_length,
    input  mbp_pkg::ctrl_cmd_t                cmd,
    output mbp_pkg::dp_status_t               status,
    output logic [7:0]                        out_byte,
    output logic [15:0]                       out_position,
    output logic                              overflow,
    output logic                              last
);

    logic [mbp_pkg::CAP_WIDTH-1:0] cap_reg;
    logic [mbp_pkg::ACC_WIDTH-1:0] acc_reg, acc_next;
    logic [mbp_pkg::LEN_WIDTH-1:0] free_reg, free_next;
    logic [mbp_pkg::POS_WIDTH-1:0] pos_reg, pos_next;
    logic                          refused_reg, refused_next;
    logic                          clear_reg, clear_next;
    logic [mbp_pkg::ACC_WIDTH-1:0] word_reg, word_next;
    logic [mbp_pkg::CNT_WIDTH-1:0] cnt_reg, cnt_next;

    logic [mbp_pkg::LEN_WIDTH-1:0] len_eff;
    logic [63:0]                   mask64;
    logic [63:0]                   v64;
    logic [mbp_pkg::LEN_WIDTH-1:0] shift_amt;
    logic [mbp_pkg::LEN_WIDTH-1:0] spill;
    logic [mbp_pkg::LEN_WIDTH-1:0] free_spill;
    logic [mbp_pkg::LEN_WIDTH-1:0] free_aligned;
    logic [mbp_pkg::LEN_WIDTH-1:0] held_bits;
    logic [mbp_pkg::CNT_WIDTH-1:0] item_cnt;
    logic [mbp_pkg::ACC_WIDTH-1:0] item_word;
    logic                          is_over;
    logic                          is_final;
    logic                          send_pending;
    mbp_pkg::req_t                 req;

    assign req          = mbp_pkg::req_t'(req_type);
    assign len_eff      = (field_length > 6'd32) ? 6'd32 : field_length;
    assign mask64       = (64'd1 << len_eff) - 64'd1;
    assign v64          = {32'd0, field_value & mask64[31:0]};
    assign shift_amt    = free_reg - len_eff;
    assign spill        = len_eff - free_reg;
    assign free_spill   = 6'd32 - spill;
    assign free_aligned = free_reg & 6'h38;
    assign held_bits    = 6'd32 - free_aligned;

    assign is_over  = pos_reg >= cap_reg;
    assign is_final = is_over || (cnt_reg == 3'd1);

    assign out_byte     = is_over ? 8'd0 : word_reg[31:24];
    assign out_position = pos_reg;
    assign overflow     = is_over;
    assign last         = is_final;
    assign status.final_word   = is_final;
    assign status.send_pending = send_pending;

    always_comb
    begin
        item_cnt  = '0;
        item_word = acc_reg | 32'(v64 >> spill);
        case (req)
            mbp_pkg::REQ_WRITE:
            begin
                if (len_eff != 6'd0 && len_eff > free_reg)
                begin
                    item_cnt = mbp_pkg::BYTES_PER_WORD;
                end
            end
            mbp_pkg::REQ_CLOSE:
            begin
                item_cnt  = held_bits[5:3];
                item_word = acc_reg;
            end
            default:
            begin
                item_cnt = '0;
            end
        endcase
    end

    always_comb
    begin
        acc_next     = acc_reg;
        free_next    = free_reg;
        pos_next     = pos_reg;
        refused_next = refused_reg;
        clear_next   = clear_reg;
        word_next    = word_reg;
        cnt_next     = cnt_reg;

        if (cmd.step)
        begin
            if (is_over)
            begin
                refused_next = 1'b1;
            end
            else
            begin
                pos_next  = pos_reg + 16'd1;
                word_next = word_reg << 8;
                cnt_next  = cnt_reg - 3'd1;
            end
            if (is_final)
            begin
                cnt_next = '0;
                if (clear_reg)
                begin
                    pos_next     = '0;
                    refused_next = 1'b0;
                    clear_next   = 1'b0;
                end
            end
        end

        send_pending = (item_cnt != 3'd0) && !refused_next;

        if (cmd.accept)
        begin
            if (send_pending)
            begin
                word_next = item_word;
                cnt_next  = item_cnt;
            end
            case (req)
                mbp_pkg::REQ_WRITE:
                begin
                    if (len_eff != 6'd0)
                    begin
                        if (len_eff <= free_reg)
                        begin
                            free_next = shift_amt;
                            acc_next  = acc_reg | 32'(v64 << shift_amt);
                        end
                        else
                        begin
                            free_next = free_spill;
                            acc_next  = 32'(v64 << free_spill);
                        end
                    end
                end
                mbp_pkg::REQ_ALIGN:
                begin
                    free_next = free_aligned;
                end
                mbp_pkg::REQ_CLOSE:
                begin
                    acc_next  = '0;
                    free_next = mbp_pkg::FREE_RESET;
                    if (send_pending)
                    begin
                        clear_next = 1'b1;
                    end
                    else
                    begin
                        pos_next     = '0;
                        refused_next = 1'b0;
                        clear_next   = 1'b0;
                    end
                end
                default:
                begin
                    acc_next     = '0;
                    free_next    = mbp_pkg::FREE_RESET;
                    pos_next     = '0;
                    refused_next = 1'b0;
                    clear_next   = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= mbp_pkg::CAP_RESET;
            acc_reg     <= '0;
            free_reg    <= mbp_pkg::FREE_RESET;
            pos_reg     <= '0;
            refused_reg <= 1'b0;
            clear_reg   <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            acc_reg     <= acc_next;
            free_reg    <= free_next;
            pos_reg     <= pos_next;
            refused_reg <= refused_next;
            clear_reg   <= clear_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // An overflow result must leave the stream refused unless a new item clears it.
    a_refuse_after_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && is_over && !clear_reg && !cmd.accept) |=> refused_reg)
        else $error("overflow result did not set the refused flag");

    a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= 6'd32)
        else $error("free bit count out of range");

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= mbp_pkg::BYTES_PER_WORD)
        else $error("byte count out of range");

    // A step is only issued while bytes remain to be sent.
    a_step_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (cnt_reg != 3'd0))
        else $error("step issued with no bytes left");

endmodule

>>> rtl/core/msb_first_bit_packer_unit.sv
// Top level of the MSB-first bit packer: joins the controller and the datapath
// and exposes the input, output and capacity write channels.
// Depends on mbp_pkg, mbp_ctrl and mbp_datapath.
//
// Each input word is taken without a stall while the block is idle. A request
// that yields no result (a write that does not overflow the accumulator, align,
// restart, or close with nothing held or after overflow) leaves the block ready
// in the next cycle. A request that yields results occupies the one-byte result
// channel for each result in turn, up to four, holding while out_stall is high,
// and the next input word is taken on the same edge as its final result. The
// capacity register accepts a write in every cycle and must only be written
// while the block is idle.
module msb_first_bit_packer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] field_value,
    input  logic [5:0]  field_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [15:0] out_position,
    output logic        overflow,
    output logic        last
);

    mbp_pkg::ctrl_cmd_t  cmd;
    mbp_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    mbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mbp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .field_value  (field_value),
        .field_length (field_length),
        .cmd          (cmd),
        .status       (status),
        .out_byte     (out_byte),
        .out_position (out_position),
        .overflow     (overflow),
        .last         (last)
    );

endmodule
